// ===== rtl/button_press_hold_detector_macros.svh =====
// assertion helpers for the button press / hold detector
`ifndef BUTTON_PRESS_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_PRESS_HOLD_DETECTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPHD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BPHD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bphd_pkg.sv =====
`default_nettype none

package bphd_pkg;

  localparam int KEY_BITS = 8;
  localparam int KEY_W    = 8;
  localparam int TICK_W   = 32;
  localparam int PHASE_W  = 3;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  localparam logic [TICK_W-1:0] HOLD_TIME_RST = TICK_W'(500);

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TIMING   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HOLD     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASED = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PRESSED  = 5'b00010,
    ST_TIMING   = 5'b00100,
    ST_HOLD     = 5'b01000,
    ST_RELEASED = 5'b10000
  } state_t;

  // first field in the highest bits
  typedef struct packed {
    logic [TICK_W-1:0] tick_now;
    logic [KEY_W-1:0]  key_sample;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   last_key;
    logic [KEY_W-1:0]   current_key;
    logic [PHASE_W-1:0] phase;
  } result_t;

  // handshake between input register and core
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  function automatic logic [PHASE_W-1:0] phase_code(input state_t st);
    logic [PHASE_W-1:0] code;
    unique case (st)
      ST_PRESSED:  code = PH_PRESSED;
      ST_TIMING:   code = PH_TIMING;
      ST_HOLD:     code = PH_HOLD;
      ST_RELEASED: code = PH_RELEASED;
      default:     code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bphd_in_reg.sv =====
`default_nettype none

module bphd_in_reg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bphd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              adv,
  output bphd_pkg::stage_t                       stage
);
  import bphd_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     in_xfer;

  assign in_tready = !s1_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  assign s1_valid_nxt = in_xfer || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item_t'(in_tdata);
    end
  end

  assign stage.valid = s1_valid_r;
  assign stage.item  = s1_item_r;

endmodule

`default_nettype wire

// ===== rtl/bphd_core.sv =====
`default_nettype none

module bphd_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bphd_pkg::TICK_W-1:0]   cfg_wr_data,
  input  wire bphd_pkg::stage_t              stage,
  output logic                               adv,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output bphd_pkg::result_t                  result
);
  import bphd_pkg::*;

  logic [TICK_W-1:0] hold_time_r;
  state_t            state_r, state_nxt;
  logic [KEY_W-1:0]  tracked_r, tracked_nxt;
  logic [KEY_W-1:0]  released_r, released_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic              out_valid_r;
  result_t           result_r;

  logic              take;
  logic [KEY_W-1:0]  key;
  logic [TICK_W-1:0] elapsed;
  logic              same_key;
  logic              key_zero;

  assign adv  = !out_valid_r || out_tready;
  assign take = stage.valid && adv;

  assign key      = stage.item.key_sample & KEY_MASK;
  assign key_zero = (key == '0);
  assign same_key = (key == tracked_r);
  // wraps modulo 2^32
  assign elapsed  = stage.item.tick_now - start_r;

  always_comb begin
    state_nxt    = state_r;
    tracked_nxt  = tracked_r;
    released_nxt = released_r;
    start_nxt    = start_r;
    unique case (state_r)
      ST_PRESSED: begin
        if (key_zero) begin
          state_nxt = ST_RELEASED;
        end else if (same_key) begin
          state_nxt = ST_TIMING;
          start_nxt = stage.item.tick_now;
        end else begin
          tracked_nxt = key;
        end
      end
      ST_TIMING: begin
        if (key_zero) begin
          state_nxt = ST_RELEASED;
        end else if (same_key) begin
          if (elapsed > hold_time_r) begin
            state_nxt = ST_HOLD;
          end
        end else begin
          tracked_nxt = key;
          state_nxt   = ST_PRESSED;
        end
      end
      ST_HOLD: begin
        if (key_zero) begin
          state_nxt = ST_RELEASED;
        end else if (!same_key) begin
          tracked_nxt = key;
          state_nxt   = ST_PRESSED;
        end
      end
      ST_RELEASED: begin
        // sample ignored here
        released_nxt = tracked_r;
        tracked_nxt  = '0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        if (!key_zero) begin
          tracked_nxt = key;
          state_nxt   = ST_PRESSED;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= HOLD_TIME_RST;
    end else if (cfg_wr_en) begin
      hold_time_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tracked_r   <= '0;
      released_r  <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r    <= state_nxt;
        tracked_r  <= tracked_nxt;
        released_r <= released_nxt;
        start_r    <= start_nxt;
      end
      if (adv) begin
        out_valid_r <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r.phase       <= phase_code(state_nxt);
      result_r.current_key <= tracked_nxt;
      result_r.last_key    <= released_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign result     = result_r;

endmodule

`default_nettype wire

// ===== rtl/button_press_hold_detector.sv =====
// Button press / hold / release detector. Each transfer on the in_ channel carries one
// sample of the button lines and the current tick count, and yields exactly one transfer
// on the out_ channel with the phase, the tracked key and the last released key after the
// update. Items pass an input register and then one state update into the result
// register. One item per clock is sustained while out_tready stays high, since the whole
// phase update (one 32-bit subtract and compare) is combinational. The hold time is to be
// written through cfg_wr_en / cfg_wr_data only while no item is in flight, which the block
// itself does not enforce; the hold time resets to 500 ticks.
`default_nettype none

module button_press_hold_detector (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bphd_pkg::TICK_W-1:0]        cfg_wr_data,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [7:0] key_sample, [39:8] tick_now
  input  wire logic [bphd_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [2:0] phase, [10:3] current_key, [18:11] last_key, [23:19] zero
  output logic [bphd_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import bphd_pkg::*;

  `include "button_press_hold_detector_macros.svh"

  stage_t  stage;
  logic    adv;
  result_t result;

  bphd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .stage     (stage)
  );

  bphd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stage       (stage),
    .adv         (adv),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .result      (result)
  );

  assign out_tdata = OUT_TDATA_W'(result);

  // idle is the only phase without a tracked key
  `BPHD_ASSERT_IMP(a_idle_no_key, out_tvalid && (result.phase == PH_IDLE), result.current_key == '0, "idle with key")
  `BPHD_ASSERT_IMP(a_busy_has_key, out_tvalid && (result.phase != PH_IDLE), result.current_key != '0, "key lost")
  `BPHD_ASSERT_IMP(a_phase_range, out_tvalid, result.phase <= PH_RELEASED, "bad phase code")
  // a full input stage with a stalled output blocks the input side
  `BPHD_ASSERT_IMP(a_stall_blocks, stage.valid && out_tvalid && !out_tready, !in_tready, "overrun")

endmodule

`default_nettype wire
